### hw/rtl/plgr_pkg.sv
// shared constants and control types for the peak limiter gain release unit
package plgr_pkg;

  localparam int unsigned NumCh    = 2;
  localparam int unsigned GainBits = 17;
  localparam int unsigned CoefBits = 16;
  localparam int unsigned QuotBits = 16;
  localparam int unsigned CntBits  = $clog2(QuotBits + 1);
  localparam int unsigned CfgBits  = 17;
  localparam int unsigned IdxBits  = 1;

  localparam logic [GainBits-1:0] Unity   = 17'd65536;
  localparam logic [GainBits-1:0] CeilMin = 17'd6554;
  localparam logic [GainBits-1:0] CeilMax = 17'd65536;

  localparam logic [IdxBits-1:0] RegCeiling = 1'd0;
  localparam logic [IdxBits-1:0] RegRelease = 1'd1;

  // per-lane control from the sequencer
  typedef struct packed {
    logic load;
    logic mul;
  } lane_ctrl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/plgr_lane.sv
// one channel lane: sample capture, magnitude, gain product, rounding and clamp
module plgr_lane #(
  parameter int unsigned SampleBits = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  plgr_pkg::lane_ctrl_t               ctrl_i,
  input  logic signed [SampleBits-1:0]       sample_i,
  input  logic [plgr_pkg::GainBits-1:0]      gain_i,
  input  logic [SampleBits-1:0]              ceil_i,
  input  logic [SampleBits-1:0]              pos_lim_i,
  output logic [SampleBits-1:0]              mag_o,
  output logic signed [SampleBits-1:0]       res_o
);

  localparam int unsigned ProdBits = SampleBits + plgr_pkg::GainBits;

  logic                      neg_q;
  logic [SampleBits-1:0]     mag_q;
  logic [ProdBits-1:0]       prod_q;
  logic [ProdBits:0]         rnd;
  logic [SampleBits+1:0]     r;
  logic [SampleBits-1:0]     lim;
  logic [SampleBits-1:0]     r_cl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else if (ctrl_i.load) begin
      neg_q <= sample_i[SampleBits-1];
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      // full negative scale maps onto 2^(n-1), which still fits unsigned
      mag_q <= sample_i[SampleBits-1] ? (~sample_i + 1'b1) : sample_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= ProdBits'(mag_q) * ProdBits'(gain_i);
    end
  end

  always_comb begin
    rnd  = {1'b0, prod_q} + (ProdBits+1)'(32768);
    r    = rnd[ProdBits:16];
    lim  = neg_q ? ceil_i : pos_lim_i;
    r_cl = (r > (SampleBits+2)'(lim)) ? lim : r[SampleBits-1:0];
    res_o = neg_q ? (~r_cl + 1'b1) : r_cl;
  end

  assign mag_o = mag_q;

endmodule

### hw/rtl/plgr_div.sv
// restoring divider, one quotient bit per cycle, for the gain target
module plgr_div #(
  parameter int unsigned SampleBits = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [SampleBits-1:0]             num_i,
  input  logic [SampleBits-1:0]             den_i,
  output plgr_pkg::div_stat_t               stat_o,
  output logic [plgr_pkg::QuotBits-1:0]     quot_o
);

  logic                            busy_q;
  logic [plgr_pkg::CntBits-1:0]    cnt_q;
  logic [SampleBits:0]             rem_q;
  logic [plgr_pkg::QuotBits-1:0]   quot_q;
  logic [SampleBits:0]             rem_sh;
  logic                            ge;

  // numerator is below the divisor on entry, so the quotient fits 16 bits
  always_comb begin
    rem_sh = {rem_q[SampleBits-1:0], 1'b0};
    ge     = rem_sh >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= plgr_pkg::CntBits'(plgr_pkg::QuotBits);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      quot_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      rem_q  <= ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
      quot_q <= {quot_q[plgr_pkg::QuotBits-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);
  assign quot_o      = quot_q;

endmodule

### hw/rtl/peak_limiter_gain_release_unit.sv
// top level: sequencer, peak merge, gain state and output register of the peak limiter
//
//   channel   direction  handshake                 payload
//   in        to block   in_valid_i / in_stall_o   sample_ch0_i, sample_ch1_i
//   out       from block out_valid_o / out_stall_i out_ch0_o, out_ch1_o
//   cfg       to block   cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// a frame passes S_PEAK, S_CMP, S_REL, S_MUL and S_OUT, and also the 16-step divider
// for ceiling/peak when its peak is above the ceiling; a release update adds S_ADD
// reset sets unity gain, a ceiling of full scale and a release step of one lsb
// in_stall_o is high while a frame is in work; a finished frame waits in the
// output register until taken, and the next frame can already be accepted
module peak_limiter_gain_release_unit #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch0_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch1_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      out_ch0_o,
  output logic signed [SAMPLE_BITS-1:0]      out_ch1_o,
  input  logic                               cfg_we_i,
  input  logic [plgr_pkg::IdxBits-1:0]       cfg_idx_i,
  input  logic [plgr_pkg::CfgBits-1:0]       cfg_wdata_i
);

  localparam int unsigned W      = SAMPLE_BITS;
  localparam int unsigned GB     = plgr_pkg::GainBits;
  localparam int unsigned RelBits = GB + plgr_pkg::CoefBits;

  typedef enum logic [2:0] {
    S_IDLE, S_PEAK, S_CMP, S_DIV, S_REL, S_ADD, S_MUL, S_OUT
  } state_e;

  state_e                            state_q;
  logic [GB-1:0]                     ceiling_q;
  logic [plgr_pkg::CoefBits-1:0]     release_q;
  logic [GB-1:0]                     gain_q;
  logic [GB-1:0]                     target_q;
  logic [W-1:0]                      peak_q;
  logic [RelBits-1:0]                rel_q;
  logic                              out_valid_q;
  logic signed [W-1:0]               out_ch0_q;
  logic signed [W-1:0]               out_ch1_q;

  logic [GB-1:0]                     ceil_cl;
  logic [W+15:0]                     ceil_ext;
  logic [W-1:0]                      ceil_s;
  logic [W-1:0]                      pos_lim;
  logic [W-1:0]                      peak_d;
  logic [GB-1:0]                     diff;
  logic [RelBits:0]                  rel_rnd;
  logic [GB:0]                       step;
  logic [GB:0]                       gain_sum;
  logic                              accept;
  logic                              div_start;
  logic                              out_free;

  plgr_pkg::lane_ctrl_t              lane_ctrl;
  plgr_pkg::div_stat_t               div_stat;
  logic [plgr_pkg::QuotBits-1:0]     quot;

  logic signed [W-1:0]               lane_smp [plgr_pkg::NumCh];
  logic [W-1:0]                      lane_mag [plgr_pkg::NumCh];
  logic signed [W-1:0]               lane_res [plgr_pkg::NumCh];

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = (state_q == S_CMP) && (peak_q > ceil_s);

  assign lane_ctrl.load = accept;
  assign lane_ctrl.mul  = (state_q == S_MUL);

  assign lane_smp[0] = sample_ch0_i;
  assign lane_smp[1] = sample_ch1_i;

  // ceiling clamped to its legal range, then moved to sample scale
  always_comb begin
    if (ceiling_q < plgr_pkg::CeilMin) begin
      ceil_cl = plgr_pkg::CeilMin;
    end else if (ceiling_q > plgr_pkg::CeilMax) begin
      ceil_cl = plgr_pkg::CeilMax;
    end else begin
      ceil_cl = ceiling_q;
    end
    ceil_ext = {ceil_cl, {(W-1){1'b0}}};
    ceil_s   = ceil_ext[W+15:16];
    pos_lim  = (ceil_s[W-1]) ? {1'b0, {(W-1){1'b1}}} : ceil_s;
  end

  // merge of the lane magnitudes into the frame peak
  always_comb begin
    peak_d = '0;
    for (int i = 0; i < plgr_pkg::NumCh; i++) begin
      if (lane_mag[i] > peak_d) begin
        peak_d = lane_mag[i];
      end
    end
  end

  // release step rounds up so the gain still reaches unity
  always_comb begin
    diff     = plgr_pkg::Unity - gain_q;
    rel_rnd  = {1'b0, rel_q} + (RelBits+1)'(65535);
    step     = rel_rnd[RelBits:16];
    gain_sum = {1'b0, gain_q} + step;
  end

  for (genvar g = 0; g < plgr_pkg::NumCh; g++) begin : g_lane
    plgr_lane #(
      .SampleBits(W)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (lane_smp[g]),
      .gain_i   (gain_q),
      .ceil_i   (ceil_s),
      .pos_lim_i(pos_lim),
      .mag_o    (lane_mag[g]),
      .res_o    (lane_res[g])
    );
  end

  plgr_div #(
    .SampleBits(W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (ceil_s),
    .den_i  (peak_q),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  // configuration decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= plgr_pkg::Unity;
      release_q <= plgr_pkg::CoefBits'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plgr_pkg::RegCeiling: ceiling_q <= cfg_wdata_i[GB-1:0];
        plgr_pkg::RegRelease: release_q <= cfg_wdata_i[plgr_pkg::CoefBits-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with gain state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= plgr_pkg::Unity;
      target_q    <= plgr_pkg::Unity;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_PEAK;
          end
        end
        S_PEAK: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (div_start) begin
            state_q <= S_DIV;
          end else begin
            target_q <= plgr_pkg::Unity;
            state_q  <= S_REL;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            target_q <= {1'b0, quot};
            state_q  <= S_REL;
          end
        end
        S_REL: begin
          if (target_q < gain_q) begin
            gain_q  <= target_q;
            state_q <= S_MUL;
          end else begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          gain_q  <= gain_sum[GB-1:0];
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_PEAK) begin
      peak_q <= peak_d;
    end
    if (state_q == S_REL) begin
      rel_q <= RelBits'(diff) * RelBits'(release_q);
    end
    if (state_q == S_OUT && out_free) begin
      out_ch0_q <= lane_res[0];
      out_ch1_q <= lane_res[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ch0_o   = out_ch0_q;
  assign out_ch1_o   = out_ch1_q;

  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= plgr_pkg::Unity)
    else $error("gain above unity");

  a_rose_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result transfer raised outside the output step");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished with no frame waiting on it");

  a_drop_to_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REL && target_q < gain_q) |=> gain_q == $past(target_q))
    else $error("gain did not drop to the target");

endmodule
